// File: sv/peer_table_with_aging_macros.svh
// assertion macros used by the peer table datapath
`ifndef PEER_TABLE_WITH_AGING_MACROS_SVH
`define PEER_TABLE_WITH_AGING_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pta_pkg.sv
// types and constants shared by the peer table modules
`timescale 1ns / 1ps
`default_nettype none

package pta_pkg;

  localparam int unsigned MAC_W       = 48;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 96;

  localparam logic [TIME_W-1:0] EXPIRY_RESET = 32'd5000;

  // operation carried in the input tuser
  typedef enum logic [1:0] {
    FUNC_BEACON = 2'd0,
    FUNC_EXPIRE = 2'd1,
    FUNC_READ   = 2'd2
  } pta_func_e;

  // result status carried in the output tuser
  typedef enum logic [2:0] {
    STAT_UPDATED  = 3'd0,
    STAT_INSERTED = 3'd1,
    STAT_DROPPED  = 3'd2,
    STAT_EXPIRED  = 3'd3,
    STAT_READ_OK  = 3'd4,
    STAT_RANGE    = 3'd5
  } pta_status_e;

  // controller to datapath
  typedef struct packed {
    logic accept;  // capture the input transaction
    logic scan;    // walk the table one slot per cycle
    logic commit;  // finish the operation and load the result
  } pta_cmd_t;

  // datapath to controller
  typedef struct packed {
    pta_func_e func;       // captured operation
    logic      scan_done;  // walk finished or beacon matched
    logic      out_free;   // result register can take a new transaction
  } pta_sts_t;

endpackage

`default_nettype wire

// File: sv/pta_ctrl.sv
// control state machine of the peer table
`timescale 1ns / 1ps
`default_nettype none

module pta_ctrl
  import pta_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire pta_sts_t sts_i,
  output pta_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // first cycle after capture also sorts out the operation
        case (sts_i.func) inside
          FUNC_BEACON, FUNC_EXPIRE: begin
            cmd_o.scan = 1'b1;
            if (sts_i.scan_done) begin
              state_d = ST_RESULT;
            end
          end
          FUNC_READ: state_d = ST_READ;
          default:   state_d = ST_RESULT;
        endcase
      end
      ST_READ: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/pta_datapath.sv
// table memory, scan pointers and result register of the peer table
`timescale 1ns / 1ps
`default_nettype none
`include "peer_table_with_aging_macros.svh"

module pta_datapath
  import pta_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [TIME_W-1:0]        cfg_wdata_i,
  input  wire logic [1:0]               in_func_i,
  input  wire logic [IN_TDATA_W-1:0]    in_data_i,
  input  wire pta_cmd_t                 cmd_i,
  output pta_sts_t                      sts_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [2:0]                    out_status_o,
  output logic [OUT_TDATA_W-1:0]        out_data_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic              role;
    logic [TIME_W-1:0] seen;
  } entry_t;

  // table memory
  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;
  logic   we;
  logic [IW-1:0] waddr, raddr;
  entry_t wdata;

  // captured operation
  pta_func_e         op_func_q;
  logic [MAC_W-1:0]  op_mac_q;
  logic              op_role_q;
  logic [TIME_W-1:0] op_now_q;
  logic [2:0]        op_ridx_q;

  logic [TIME_W-1:0] expiry_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, kept_q;
  logic [IW-1:0]     chk_q, slot_q;
  logic              pend_q, match_q;

  logic              issue, hit, keep, rd_ok, out_free;
  logic [TIME_W-1:0] age;

  // result register
  logic              out_valid_q;
  logic [2:0]        res_status_d, res_status_q;
  logic [2:0]        res_slot_d, res_slot_q;
  logic [3:0]        res_count_d, res_count_q;
  logic [3:0]        res_removed_d, res_removed_q;
  entry_t            res_entry_d, res_entry_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign issue    = idx_q < cnt_q;
  assign age      = op_now_q - rdata_q.seen;
  assign hit      = pend_q && (op_func_q == FUNC_BEACON) && (rdata_q.mac == op_mac_q);
  assign keep     = age < expiry_q;
  assign rd_ok    = (CW + 3)'(op_ridx_q) < (CW + 3)'(cnt_q);

  assign sts_o.func      = op_func_q;
  assign sts_o.scan_done = hit || (!pend_q && !issue);
  assign sts_o.out_free  = out_free;

  // read address: walk pointer while scanning, read index otherwise
  always_comb begin
    if (cmd_i.scan) begin
      raddr = issue ? idx_q[IW-1:0] : '0;
    end else begin
      raddr = IW'(op_ridx_q);
    end
  end

  // write port, commit path and result fields
  always_comb begin
    we            = 1'b0;
    waddr         = '0;
    wdata         = rdata_q;
    cnt_d         = cnt_q;
    res_status_d  = STAT_RANGE;
    res_slot_d    = '0;
    res_count_d   = 4'(cnt_q);
    res_removed_d = '0;
    res_entry_d   = '0;
    if (cmd_i.scan) begin
      if (hit) begin
        // refresh role and last-seen time of the matching peer
        we         = 1'b1;
        waddr      = chk_q;
        wdata.role = op_role_q;
        wdata.seen = op_now_q;
      end else if (pend_q && (op_func_q == FUNC_EXPIRE) && keep) begin
        // move a kept entry down to the compacted position
        we    = 1'b1;
        waddr = kept_q[IW-1:0];
      end
    end
    if (cmd_i.commit) begin
      case (op_func_q)
        FUNC_BEACON: begin
          if (match_q) begin
            res_status_d = STAT_UPDATED;
            res_slot_d   = 3'(slot_q);
          end else if (cnt_q >= CW'(TABLE_DEPTH)) begin
            res_status_d = STAT_DROPPED;
          end else begin
            we           = 1'b1;
            waddr        = cnt_q[IW-1:0];
            wdata.mac    = op_mac_q;
            wdata.role   = op_role_q;
            wdata.seen   = op_now_q;
            cnt_d        = cnt_q + CW'(1);
            res_status_d = STAT_INSERTED;
            res_slot_d   = 3'(cnt_q);
            res_count_d  = 4'(cnt_d);
          end
        end
        FUNC_EXPIRE: begin
          cnt_d         = kept_q;
          res_status_d  = STAT_EXPIRED;
          res_count_d   = 4'(kept_q);
          res_removed_d = 4'(cnt_q - kept_q);
        end
        FUNC_READ: begin
          if (rd_ok) begin
            res_status_d = STAT_READ_OK;
            res_slot_d   = op_ridx_q;
            res_entry_d  = rdata_q;
          end
        end
        default: res_status_d = STAT_RANGE;
      endcase
    end
  end

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
  end

  // operation capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_func_q <= pta_func_e'(in_func_i);
      op_mac_q  <= in_data_i[47:0];
      op_role_q <= in_data_i[48];
      op_now_q  <= in_data_i[80:49];
      op_ridx_q <= in_data_i[83:81];
    end
  end

  // walk pointers and match tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      kept_q  <= '0;
      chk_q   <= '0;
      slot_q  <= '0;
      pend_q  <= 1'b0;
      match_q <= 1'b0;
    end else if (cmd_i.accept) begin
      idx_q   <= '0;
      kept_q  <= '0;
      pend_q  <= 1'b0;
      match_q <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q  <= idx_q + CW'(issue);
      chk_q  <= idx_q[IW-1:0];
      pend_q <= issue;
      if (hit) begin
        match_q <= 1'b1;
        slot_q  <= chk_q;
      end
      if (pend_q && (op_func_q == FUNC_EXPIRE) && keep) begin
        kept_q <= kept_q + CW'(1);
      end
    end
  end

  // valid count and expiry register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      expiry_q <= EXPIRY_RESET;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        expiry_q <= cfg_wdata_i;
      end
    end
  end

  // result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_status_q  <= res_status_d;
      res_slot_q    <= res_slot_d;
      res_count_q   <= res_count_d;
      res_removed_q <= res_removed_d;
      res_entry_q   <= res_entry_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = res_status_q;
  assign out_data_o   = {4'b0, res_entry_q.seen, res_entry_q.role, res_entry_q.mac,
                         res_removed_q, res_count_q, res_slot_q};

  `PTA_ASSERT_NOW(a_count_bound, 1'b1, cnt_q <= CW'(TABLE_DEPTH), "valid count beyond depth")
  `PTA_ASSERT_NOW(a_kept_behind, cmd_i.scan, kept_q <= idx_q, "compaction ahead of walk")
  `PTA_ASSERT_NOW(a_commit_free, cmd_i.commit, out_free, "result loaded over pending data")
  `PTA_ASSERT_NEXT(a_expire_shrinks, cmd_i.commit && (op_func_q == FUNC_EXPIRE),
                   cnt_q <= $past(cnt_q), "expire pass grew the table")

endmodule

`default_nettype wire

// File: sv/peer_table_with_aging.sv
// Peer table with aging: a dense, ordered table of up to TABLE_DEPTH peers
// (MAC, role, last-seen time) held in one memory with a single read and a
// single write port. Every input transaction gives one result transaction.
// A beacon walks the valid entries one per cycle and stops at the first
// matching MAC; an expire pass walks all valid entries and compacts the
// kept ones in place as it goes. The walk goes through the memory read
// port, so each slot is read into a register before it is checked. A new
// transaction is taken while the last result is still waiting on the
// output register. The user must write expiry_ms through cfg_we_i /
// cfg_wdata_i only while the block is idle; the block itself does not
// enforce this.
`timescale 1ns / 1ps
`default_nettype none

module peer_table_with_aging
  import pta_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // expiry threshold in milliseconds
  input  wire logic                   cfg_we_i,
  input  wire logic [TIME_W-1:0]      cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [47:0] peer_mac, [48] peer_role, [80:49] now_ms, [83:81] read_index
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] func
  input  wire logic [1:0]             s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [2:0] slot, [6:3] entry_count, [10:7] removed_count, [58:11] entry_mac,
  // [59] entry_role, [91:60] entry_seen_ms
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // [2:0] status
  output logic [2:0]                  m_axis_tuser
);

  pta_cmd_t cmd;
  pta_sts_t sts;

  // sequencing of each operation
  pta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table storage and result path
  pta_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_func_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: bench/peer_table_with_aging_test.sv
// self-checking testbench for the peer table with aging
`timescale 1ns / 1ps

module peer_table_with_aging_test
  import pta_pkg::*;
();

  localparam int TABLE_DEPTH = 8;
  localparam int POOL_SIZE   = 12;
  // operation code with no meaning, answered as out of range
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // one result transaction split into its fields
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [3:0]  count;
    logic [3:0]  removed;
    logic [47:0] mac;
    logic        role;
    logic [31:0] seen;
  } peer_reply_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [TIME_W-1:0]      cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [47:0] peer_mac, [48] peer_role, [80:49] now_ms, [83:81] read_index
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // [1:0] func
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [2:0] slot, [6:3] entry_count, [10:7] removed_count, [58:11] entry_mac,
  // [59] entry_role, [91:60] entry_seen_ms
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [2:0] status
  logic [2:0]             m_axis_tuser;

  // predicted table contents and register
  logic [47:0] peer_mac [TABLE_DEPTH];
  logic        peer_role [TABLE_DEPTH];
  logic [31:0] peer_seen [TABLE_DEPTH];
  int          peer_count = 0;
  logic [31:0] expiry_ms = EXPIRY_RESET;

  peer_reply_t peer_replies_q[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  logic [31:0] cur_ms = '0;
  int          step_max = 1000;
  logic [47:0] mac_pool [POOL_SIZE];

  peer_table_with_aging #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // apply one operation to the predicted table and return its reply
  function automatic peer_reply_t peer_table_apply(logic [1:0] func, logic [47:0] mac,
                                                   logic role, logic [31:0] now,
                                                   logic [2:0] idx);
    peer_reply_t r;
    int          kept;
    bit          hit;
    logic [31:0] age;
    r    = '0;
    kept = 0;
    hit  = 1'b0;
    case (func)
      FUNC_BEACON: begin
        // refresh the first matching peer, else append if room is left
        for (int i = 0; i < peer_count; i++) begin
          if (!hit && peer_mac[i] == mac) begin
            peer_role[i] = role;
            peer_seen[i] = now;
            r.status     = STAT_UPDATED;
            r.slot       = 3'(i);
            hit          = 1'b1;
          end
        end
        if (!hit) begin
          if (peer_count >= TABLE_DEPTH) begin
            r.status = STAT_DROPPED;
          end else begin
            peer_mac[peer_count]  = mac;
            peer_role[peer_count] = role;
            peer_seen[peer_count] = now;
            r.status              = STAT_INSERTED;
            r.slot                = 3'(peer_count);
            peer_count++;
          end
        end
      end
      FUNC_EXPIRE: begin
        // keep young entries, moved down in order
        for (int i = 0; i < peer_count; i++) begin
          age = now - peer_seen[i];
          if (age < expiry_ms) begin
            peer_mac[kept]  = peer_mac[i];
            peer_role[kept] = peer_role[i];
            peer_seen[kept] = peer_seen[i];
            kept++;
          end
        end
        r.status   = STAT_EXPIRED;
        r.removed  = 4'(peer_count - kept);
        peer_count = kept;
      end
      FUNC_READ: begin
        if (int'(idx) < peer_count) begin
          r.status = STAT_READ_OK;
          r.slot   = idx;
          r.mac    = peer_mac[idx];
          r.role   = peer_role[idx];
          r.seen   = peer_seen[idx];
        end else begin
          r.status = STAT_RANGE;
        end
      end
      default: begin
        r.status = STAT_RANGE;
      end
    endcase
    r.count = 4'(peer_count);
    return r;
  endfunction

  // offer one transaction, called just after a falling edge
  task automatic send_item(logic [1:0] func, logic [47:0] mac, logic role,
                           logic [31:0] now, logic [2:0] idx);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {4'b0, idx, now, role, mac};
    s_axis_tuser  = func;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    peer_replies_q.push_back(peer_table_apply(func, mac, role, now, idx));
    @(negedge clk_i);
  endtask

  // stop sending and wait until every reply is back
  task automatic wait_replies_done();
    s_axis_tvalid = 1'b0;
    while (peer_replies_q.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // write the expiry threshold while the block is idle
  task automatic set_expiry(logic [31:0] value);
    wait_replies_done();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    expiry_ms   = value;
    if (value <= 3) step_max = 2;
    else if (value > 30000) step_max = 30000;
    else step_max = value / 3;
  endtask

  // mostly beacons from a small peer set, with expires, reads and some noise
  task automatic random_item();
    int          pick;
    logic [1:0]  func;
    logic [47:0] mac;
    logic [2:0]  idx;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 4) cur_ms = $urandom();
    else cur_ms = cur_ms + 32'($urandom_range(step_max, 0));
    mac = mac_pool[$urandom_range(POOL_SIZE - 1)];
    idx = 3'($urandom_range(7));
    if (pick < 50) begin
      func = FUNC_BEACON;
    end else if (pick < 65) begin
      func = FUNC_EXPIRE;
    end else if (pick < 95) begin
      func = FUNC_READ;
      if (pick < 90 && peer_count > 0) idx = 3'($urandom_range(peer_count - 1));
    end else if (pick < 97) begin
      func = FUNC_UNUSED;
    end else begin
      func = FUNC_BEACON;
      mac  = 48'({$urandom(), $urandom()});
    end
    send_item(func, mac, 1'($urandom_range(1)), cur_ms, idx);
  endtask

  task automatic fill_mac_pool();
    for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = 48'({$urandom(), $urandom()});
    mac_pool[0] = '0;
    mac_pool[1] = MAC_ONES;
  endtask

  // empty table: reads, expire and an unknown operation
  task automatic test_empty_table();
    send_item(FUNC_READ, '0, 1'b0, '0, 3'd0);
    send_item(FUNC_READ, '0, 1'b0, '0, 3'd7);
    send_item(FUNC_EXPIRE, '0, 1'b0, '0, 3'd0);
    send_item(FUNC_UNUSED, MAC_ONES, 1'b1, TIME_MAX, 3'd7);
  endtask

  // fill to full, drop, update when full, then age out with compaction
  task automatic test_fill_and_age();
    send_item(FUNC_BEACON, '0, 1'b0, '0, 3'd0);
    send_item(FUNC_BEACON, MAC_ONES, 1'b1, TIME_MAX, 3'd0);
    send_item(FUNC_BEACON, '0, 1'b1, 32'd100, 3'd0);
    for (int i = 1; i <= 6; i++) begin
      send_item(FUNC_BEACON, 48'(i), 1'(i), 32'(100 + 100 * i), 3'd0);
    end
    send_item(FUNC_BEACON, 48'h123, 1'b0, 32'd800, 3'd0);
    send_item(FUNC_BEACON, MAC_ONES, 1'b1, 32'd4000, 3'd0);
    send_item(FUNC_READ, '0, 1'b0, '0, 3'd7);
    send_item(FUNC_READ, '0, 1'b0, '0, 3'd0);
    send_item(FUNC_READ, '0, 1'b0, '0, 3'd1);
    // the oldest entry reaches the threshold exactly
    send_item(FUNC_EXPIRE, '0, 1'b0, 32'd5100, 3'd0);
    // an entry in the middle goes, the rest move down
    send_item(FUNC_EXPIRE, '0, 1'b0, 32'd5250, 3'd0);
    send_item(FUNC_READ, '0, 1'b0, '0, 3'd1);
  endtask

  // threshold extremes, with the age taken across the time wrap
  task automatic test_expiry_extremes();
    set_expiry(TIME_MAX);
    send_item(FUNC_BEACON, 48'h777, 1'b0, 32'd5, 3'd0);
    send_item(FUNC_EXPIRE, '0, 1'b0, 32'd4, 3'd0);
    set_expiry(32'd1);
    send_item(FUNC_BEACON, 48'd2, 1'b1, 32'd9000, 3'd0);
    send_item(FUNC_EXPIRE, '0, 1'b0, 32'd9000, 3'd0);
    send_item(FUNC_READ, '0, 1'b0, '0, 3'd0);
    // a zero threshold empties the table
    set_expiry(32'd0);
    send_item(FUNC_EXPIRE, '0, 1'b0, 32'd9000, 3'd0);
    send_item(FUNC_READ, '0, 1'b0, '0, 3'd0);
  endtask

  task automatic random_phase(int n, int send_pct, int recv_pct, logic [31:0] expiry);
    set_expiry(expiry);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    fill_mac_pool();
    repeat (n) random_item();
  endtask

  // random traffic under each idling pattern and several thresholds
  task automatic test_random_traffic();
    random_phase(100, 0, 0, EXPIRY_RESET);
    random_phase(100, 84, 0, 32'd1);
    random_phase(100, 0, 84, 32'($urandom_range(50000, 50)));
    random_phase(100, 9, 9, TIME_MAX);
  endtask

  // receiver holds off long enough to back up the input
  task automatic test_backpressure();
    set_expiry(32'd2000);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    repeat (20) random_item();
    wait_replies_done();
    repeat (10) random_item();
    wait_replies_done();
  endtask

  // receiver ready, with random stalls and long hold-offs
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare each result transaction with the oldest prediction
  initial begin
    peer_reply_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (peer_replies_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h %0h", $time,
                   m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = peer_replies_q.pop_front();
          check_field("status", 48'(want.status), 48'(m_axis_tuser));
          check_field("slot", 48'(want.slot), 48'(m_axis_tdata[2:0]));
          check_field("entry_count", 48'(want.count), 48'(m_axis_tdata[6:3]));
          check_field("removed_count", 48'(want.removed), 48'(m_axis_tdata[10:7]));
          check_field("entry_mac", want.mac, m_axis_tdata[58:11]);
          check_field("entry_role", 48'(want.role), 48'(m_axis_tdata[59]));
          check_field("entry_seen_ms", 48'(want.seen), 48'(m_axis_tdata[91:60]));
        end
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_table();
    test_fill_and_age();
    test_expiry_extremes();
    test_random_traffic();
    test_backpressure();
    wait_replies_done();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
